@@ rtl/wafo_pkg.sv @@
// ----------------------------------------------------------------------------
// wafo_pkg: shared types and constants of the wheel angle frame odometer
// Holds the configuration and frame record types, register indexes, reset
// values and the fixed geometry of the reply frame and of the queues.
// ----------------------------------------------------------------------------
package wafo_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEFT_ADDR  = 3'd0;
    localparam logic [2:0] CFG_RIGHT_ADDR = 3'd1;
    localparam logic [2:0] CFG_CMD_BYTE   = 3'd2;
    localparam logic [2:0] CFG_END_BYTE   = 3'd3;
    localparam logic [2:0] CFG_MM_SCALE   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_LEFT_ADDR  = 8'd3;
    localparam logic [7:0]  RST_RIGHT_ADDR = 8'd4;
    localparam logic [7:0]  RST_CMD_BYTE   = 8'h36;
    localparam logic [7:0]  RST_END_BYTE   = 8'h6B;
    localparam logic [23:0] RST_MM_SCALE   = 24'd76404;

    // Byte positions inside a reply frame.
    localparam logic [2:0] POS_ADDR = 3'd0;
    localparam logic [2:0] POS_CMD  = 3'd1;
    localparam logic [2:0] POS_SIGN = 3'd2;
    localparam logic [2:0] POS_END  = 3'd7;

    // Angle wrap correction, 65536 counts per turn.
    localparam logic signed [34:0] HALF_TURN = 35'sd32768;
    localparam logic signed [34:0] FULL_TURN = 35'sd65536;

    // Output saturation limits, signed 48 bit.
    localparam logic [47:0] OUT_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] OUT_MIN = {1'b1, {47{1'b0}}};

    // Result queue depth.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [7:0]  left_addr;
        logic [7:0]  right_addr;
        logic [7:0]  cmd_byte;
        logic [7:0]  end_byte;
        logic [23:0] mm_scale;
    } t_cfg;

    // One checked frame, already tagged with its wheel.
    typedef struct packed {
        logic        is_left;
        logic        sign_nz;
        logic [31:0] angle;
    } t_frame;

endpackage

@@ rtl/wafo_front.sv @@
// ----------------------------------------------------------------------------
// wafo_front: reply frame assembler
// Hunts for a wheel address, checks the command and end bytes, collects the
// big-endian angle and hands each good frame on as a tagged record.
// ----------------------------------------------------------------------------
module wafo_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wafo_pkg::t_cfg  i_cfg,
    input  logic            i_acc,
    input  logic [7:0]      i_byte,
    output logic            o_frm_vld,
    output wafo_pkg::t_frame o_frm
);
    import wafo_pkg::*;

    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_addr;
    logic        r_sign;
    logic [31:0] r_angle;
    logic        is_left;
    logic        is_right;

    // Address is matched against the registers when the frame completes.
    assign is_left  = (r_addr == i_cfg.left_addr);
    assign is_right = (r_addr == i_cfg.right_addr);

    always_comb begin
        n_cnt = r_cnt;
        if (i_acc) begin
            unique case (r_cnt)
                POS_ADDR: begin
                    if (i_byte == i_cfg.left_addr || i_byte == i_cfg.right_addr) begin
                        n_cnt = POS_CMD;
                    end
                end
                POS_CMD: begin
                    n_cnt = (i_byte == i_cfg.cmd_byte) ? POS_SIGN : POS_ADDR;
                end
                default: begin
                    n_cnt = r_cnt + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= POS_ADDR;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            if (r_cnt == POS_ADDR) begin
                r_addr <= i_byte;
            end
            if (r_cnt == POS_SIGN) begin
                r_sign <= (i_byte != 8'd0);
            end
            if (r_cnt != POS_ADDR && r_cnt != POS_CMD && r_cnt != POS_SIGN
                && r_cnt != POS_END) begin
                r_angle <= {r_angle[23:0], i_byte};
            end
        end
    end

    assign o_frm_vld = i_acc && (r_cnt == POS_END) && (i_byte == i_cfg.end_byte)
                       && (is_left || is_right);
    assign o_frm.is_left = is_left;
    assign o_frm.sign_nz = r_sign;
    assign o_frm.angle   = r_angle;

endmodule

@@ rtl/wafo_frame_q.sv @@
// ----------------------------------------------------------------------------
// wafo_frame_q: two-entry frame queue
// Decouples the frame assembler from the wheel update and scaling pipeline.
// ----------------------------------------------------------------------------
module wafo_frame_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  wafo_pkg::t_frame i_data,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_vld,
    output wafo_pkg::t_frame o_data
);
    import wafo_pkg::*;

    t_frame     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_wr;
    logic       do_rd;

    assign do_wr  = i_wr && (r_cnt != 2'd2);
    assign do_rd  = i_rd && (r_cnt != 2'd0);
    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wp <= ~r_wp;
            end
            if (do_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/wafo_back.sv @@
// ----------------------------------------------------------------------------
// wafo_back: wheel update, scaling pipeline and result queue
// Turns frames into wheel deltas, and when both wheels hold one scales half
// their difference to Q16 millimeters through a four-stage pipeline.
// ----------------------------------------------------------------------------
module wafo_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wafo_pkg::t_cfg   i_cfg,
    input  logic             i_frm_vld,
    input  wafo_pkg::t_frame i_frm,
    output logic             o_frm_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [47:0]      o_result
);
    import wafo_pkg::*;

    // Wheel state.
    logic                r_left_seen, r_right_seen;
    logic                r_left_ready, r_right_ready;
    logic signed [32:0]  r_left_last, r_right_last;
    logic signed [34:0]  r_left_delta, r_right_delta;

    // Scaling pipeline.
    logic                r_emit;
    logic                r_diff_vld;
    logic signed [35:0]  r_diff;
    logic                r_prod_vld;
    logic [41:0]         r_pl;
    logic signed [42:0]  r_ph;
    logic                r_res_vld;
    logic [47:0]         r_res;

    // Result queue.
    logic [47:0]         r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp, r_rp;
    logic [OQ_PTR_W:0]   r_cnt;

    logic [2:0]          inflight;
    logic [OQ_PTR_W+1:0] occupancy;
    logic                pop_frm;
    logic signed [32:0]  angle;
    logic signed [32:0]  last;
    logic signed [33:0]  d_raw;
    logic signed [34:0]  d_ext;
    logic signed [34:0]  d_fix;
    logic                n_left_ready, n_right_ready;
    logic [41:0]         pl;
    logic signed [42:0]  ph;
    logic signed [60:0]  prod;
    logic signed [60:0]  rounded;
    logic [51:0]         quot;
    logic [47:0]         sat;
    logic                oq_rd;

    // A frame is taken only when every result it could start has a queue slot.
    assign inflight  = 3'(r_emit) + 3'(r_diff_vld) + 3'(r_prod_vld) + 3'(r_res_vld);
    assign occupancy = (OQ_PTR_W+2)'(r_cnt) + (OQ_PTR_W+2)'(inflight);
    assign pop_frm   = i_frm_vld && (occupancy < (OQ_PTR_W+2)'(OQ_DEPTH));
    assign o_frm_rd  = pop_frm;

    assign angle = i_frm.sign_nz ? -$signed({1'b0, i_frm.angle})
                                 :  $signed({1'b0, i_frm.angle});
    assign last  = i_frm.is_left ? r_left_last : r_right_last;
    assign d_raw = 34'(angle) - 34'(last);
    assign d_ext = 35'(d_raw);

    always_comb begin
        priority if (d_ext > HALF_TURN) begin
            d_fix = d_ext - FULL_TURN;
        end else if (d_ext < -HALF_TURN) begin
            d_fix = d_ext + FULL_TURN;
        end else begin
            d_fix = d_ext;
        end
    end

    always_comb begin
        n_left_ready  = r_left_ready;
        n_right_ready = r_right_ready;
        if (pop_frm) begin
            if (i_frm.is_left && r_left_seen) begin
                n_left_ready = 1'b1;
            end
            if (!i_frm.is_left && r_right_seen) begin
                n_right_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_seen   <= 1'b0;
            r_right_seen  <= 1'b0;
            r_left_ready  <= 1'b0;
            r_right_ready <= 1'b0;
            r_left_last   <= '0;
            r_right_last  <= '0;
            r_left_delta  <= '0;
            r_right_delta <= '0;
            r_emit        <= 1'b0;
        end else begin
            if (pop_frm) begin
                if (i_frm.is_left) begin
                    r_left_seen <= 1'b1;
                    r_left_last <= angle;
                    if (r_left_seen) begin
                        r_left_delta <= d_fix;
                    end
                end else begin
                    r_right_seen <= 1'b1;
                    r_right_last <= angle;
                    if (r_right_seen) begin
                        r_right_delta <= d_fix;
                    end
                end
            end
            r_emit <= n_left_ready && n_right_ready;
            if (n_left_ready && n_right_ready) begin
                r_left_ready  <= 1'b0;
                r_right_ready <= 1'b0;
            end else begin
                r_left_ready  <= n_left_ready;
                r_right_ready <= n_right_ready;
            end
        end
    end

    // The product is split at bit 18 of the difference into two partial products.
    assign pl = r_diff[17:0] * i_cfg.mm_scale;
    assign ph = $signed(r_diff[35:18]) * $signed({1'b0, i_cfg.mm_scale});

    // Rounding to nearest, ties up: add half of the dropped 2^9 step and floor.
    assign prod    = $signed({r_ph, 18'd0}) + $signed({19'd0, r_pl});
    assign rounded = prod + 61'sd256;
    assign quot    = rounded[60:9];

    always_comb begin
        if (quot[51:47] == {5{quot[51]}}) begin
            sat = quot[47:0];
        end else begin
            sat = quot[51] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_vld <= 1'b0;
            r_prod_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_diff_vld <= r_emit;
            r_prod_vld <= r_diff_vld;
            r_res_vld  <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit) begin
            r_diff <= 36'(r_left_delta) - 36'(r_right_delta);
        end
        if (r_diff_vld) begin
            r_pl <= pl;
            r_ph <= ph;
        end
        if (r_prod_vld) begin
            r_res <= sat;
        end
    end

    assign oq_rd    = i_pop && (r_cnt != '0);
    assign o_empty  = (r_cnt == '0);
    assign o_result = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_res_vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (oq_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_PTR_W+1)'(r_res_vld) - (OQ_PTR_W+1)'(oq_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_vld) begin
            r_oq[r_wp] <= r_res;
        end
    end

    a_no_both_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_left_ready && r_right_ready))
        else $error("both wheel ready flags left set");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (!r_left_ready && !r_right_ready))
        else $error("ready flags not cleared on emit");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (OQ_PTR_W+2)'(OQ_DEPTH))
        else $error("result queue overcommitted");

endmodule

@@ rtl/wheel_angle_frame_odometer_core.sv @@
// ----------------------------------------------------------------------------
// wheel_angle_frame_odometer_core: wheel odometry from motor reply frames
// Usage:
//   Input queue side: drive a received bus byte on i_rx_byte with push; a
//   byte is taken at a clock edge where push is high and full is low. One
//   byte per cycle is sustained while full is low; full rises only while
//   two good frames wait in the frame queue for the scaling pipeline.
//   Result queue side: while empty is low, o_half_delta_mm_q16 holds the
//   oldest result; pop high at a clock edge takes it. Up to eight results
//   are buffered; when the receiver stalls, frames back up into the frame
//   queue and then full holds off the byte stream.
//   Path: after the end byte of the frame that completes it, a result passes
//   through the frame queue, wheel update, difference, partial products,
//   rounding and saturation before it becomes visible.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (left address, right address, command byte, end byte, scale); the user
//   must see that it is used only while the block is idle, as the block does not enforce it.
//   Reset (i_rst_n low, synchronous) restores the register defaults, drops
//   any partial frame, forgets both wheels and empties both queues.
// ----------------------------------------------------------------------------
module wheel_angle_frame_odometer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          i_rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [47:0]                         o_half_delta_mm_q16,
    input  logic                                i_cfg_we,
    input  logic [wafo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wafo_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import wafo_pkg::*;

    t_cfg   r_cfg;
    logic   acc;
    logic   frm_vld;
    t_frame frm;
    logic   fq_full;
    logic   fq_vld;
    t_frame fq_data;
    logic   fq_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_addr  <= RST_LEFT_ADDR;
            r_cfg.right_addr <= RST_RIGHT_ADDR;
            r_cfg.cmd_byte   <= RST_CMD_BYTE;
            r_cfg.end_byte   <= RST_END_BYTE;
            r_cfg.mm_scale   <= RST_MM_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_ADDR:  r_cfg.left_addr  <= i_cfg_wdata[7:0];
                CFG_RIGHT_ADDR: r_cfg.right_addr <= i_cfg_wdata[7:0];
                CFG_CMD_BYTE:   r_cfg.cmd_byte   <= i_cfg_wdata[7:0];
                CFG_END_BYTE:   r_cfg.end_byte   <= i_cfg_wdata[7:0];
                CFG_MM_SCALE:   r_cfg.mm_scale   <= i_cfg_wdata[23:0];
                default: begin
                end
            endcase
        end
    end

    assign full = fq_full;
    assign acc  = push && !fq_full;

    wafo_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_acc     (acc),
        .i_byte    (i_rx_byte),
        .o_frm_vld (frm_vld),
        .o_frm     (frm)
    );

    wafo_frame_q u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (frm_vld),
        .i_data  (frm),
        .i_rd    (fq_rd),
        .o_full  (fq_full),
        .o_vld   (fq_vld),
        .o_data  (fq_data)
    );

    wafo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_frm_vld (fq_vld),
        .i_frm     (fq_data),
        .o_frm_rd  (fq_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_half_delta_mm_q16)
    );

endmodule

@@ tb/sv/wheel_angle_frame_odometer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_angle_frame_odometer_core_tb: self-checking bench of the wheel odometer
// Feeds motor reply bytes through the input queue, keeps its own bit-exact
// model of the frame hunter, wheel tracking and Q32.16 scaling, and checks
// every popped travel value in order. Directed frames cover framing errors,
// turn wrap, register extremes and saturation; random traffic with idle
// bursts, a long result stall and a final streaming phase follows.
// ----------------------------------------------------------------------------
module wheel_angle_frame_odometer_core_tb;
    import wafo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam longint ANGLE_LIMIT  = 64'sd4294967295;
    localparam longint TRAVEL_MAX   = 64'sd140737488355327;
    localparam longint TRAVEL_MIN   = -TRAVEL_MAX - 1;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     RANDOM_BYTES  = 150;
    localparam int     RANDOM_RESULTS = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [7:0]            i_rx_byte;
    logic                  empty;
    logic                  pop;
    logic [47:0]           o_half_delta_mm_q16;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    wheel_angle_frame_odometer_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_half_delta_mm_q16 (o_half_delta_mm_q16),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    // Odometer model state.
    t_cfg               model_cfg;
    logic [2:0]         frame_pos;
    logic [7:0]         frame_bytes [8];
    bit                 left_seen, right_seen, left_ready, right_ready;
    logic signed [32:0] left_angle, right_angle;
    logic signed [34:0] left_step, right_step;

    logic [47:0] travel_q [$];
    logic [47:0] travel_expected;
    int          travel_made;
    int          bytes_sent;
    int          errors;
    int          stall_cycles;
    int          tx_gap_pct;
    int          rx_gap_pct;
    int          rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function void reset_model();
        model_cfg.left_addr  = RST_LEFT_ADDR;
        model_cfg.right_addr = RST_RIGHT_ADDR;
        model_cfg.cmd_byte   = RST_CMD_BYTE;
        model_cfg.end_byte   = RST_END_BYTE;
        model_cfg.mm_scale   = RST_MM_SCALE;
        frame_pos = POS_ADDR;
        foreach (frame_bytes[k]) frame_bytes[k] = 8'd0;
        left_seen = 1'b0;
        right_seen = 1'b0;
        left_ready = 1'b0;
        right_ready = 1'b0;
        left_angle = '0;
        right_angle = '0;
        left_step = '0;
        right_step = '0;
    endfunction

    function void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LEFT_ADDR:  model_cfg.left_addr  = data[7:0];
            CFG_RIGHT_ADDR: model_cfg.right_addr = data[7:0];
            CFG_CMD_BYTE:   model_cfg.cmd_byte   = data[7:0];
            CFG_END_BYTE:   model_cfg.end_byte   = data[7:0];
            CFG_MM_SCALE:   model_cfg.mm_scale   = data;
            default: ;
        endcase
    endfunction

    // A step of more than half a turn is taken as a wrap and corrected once.
    function automatic longint unwrap_turn(input longint d);
        if (d > longint'(HALF_TURN)) return d - longint'(FULL_TURN);
        if (d < -longint'(HALF_TURN)) return d + longint'(FULL_TURN);
        return d;
    endfunction

    function automatic logic [47:0] half_travel_q16();
        longint diff;
        longint prod;
        longint q;
        diff = longint'(left_step) - longint'(right_step);
        prod = diff * longint'({40'd0, model_cfg.mm_scale});
        // Halve and drop from Q.24 to Q.16, rounding ties upward.
        q = (prod + 64'sd256) >>> 9;
        if (q > TRAVEL_MAX) q = TRAVEL_MAX;
        if (q < TRAVEL_MIN) q = TRAVEL_MIN;
        return q[47:0];
    endfunction

    function void finish_frame();
        logic [31:0] raw;
        longint      ang;
        longint      d;
        raw = {frame_bytes[3], frame_bytes[4], frame_bytes[5], frame_bytes[6]};
        ang = longint'({32'd0, raw});
        if (frame_bytes[POS_SIGN] != 8'd0) ang = -ang;
        if (frame_bytes[POS_ADDR] == model_cfg.left_addr) begin
            if (!left_seen) begin
                left_angle = ang[32:0];
                left_seen = 1'b1;
                return;
            end
            d = unwrap_turn(ang - longint'(left_angle));
            left_step = d[34:0];
            left_angle = ang[32:0];
            left_ready = 1'b1;
        end else if (frame_bytes[POS_ADDR] == model_cfg.right_addr) begin
            if (!right_seen) begin
                right_angle = ang[32:0];
                right_seen = 1'b1;
                return;
            end
            d = unwrap_turn(ang - longint'(right_angle));
            right_step = d[34:0];
            right_angle = ang[32:0];
            right_ready = 1'b1;
        end else begin
            return;
        end
        if (left_ready && right_ready) begin
            travel_q.push_back(half_travel_q16());
            travel_made++;
            left_ready = 1'b0;
            right_ready = 1'b0;
        end
    endfunction

    function void track_byte(input logic [7:0] b);
        if (frame_pos == POS_ADDR) begin
            if (b == model_cfg.left_addr || b == model_cfg.right_addr) begin
                frame_bytes[POS_ADDR] = b;
                frame_pos = POS_CMD;
            end
        end else if (frame_pos == POS_CMD && b != model_cfg.cmd_byte) begin
            // The wrong byte is dropped, not taken as a new address.
            frame_pos = POS_ADDR;
        end else begin
            frame_bytes[frame_pos] = b;
            if (frame_pos == POS_END) begin
                if (b == model_cfg.end_byte) finish_frame();
                frame_pos = POS_ADDR;
            end else begin
                frame_pos = frame_pos + 3'd1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: pop driver, checker and watchdog
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req != 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
                pop <= 1'b0;
                repeat (hold_left) @(posedge i_clk);
            end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (travel_q.size() == 0) begin
                $display("%0t: half_delta_mm_q16 unexpected transaction: expected none, actual %h",
                         $time, o_half_delta_mm_q16);
                errors++;
            end else begin
                travel_expected = travel_q.pop_front();
                if (o_half_delta_mm_q16 !== travel_expected) begin
                    $display("%0t: half_delta_mm_q16 mismatch: expected %h, actual %h",
                             $time, travel_expected, o_half_delta_mm_q16);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("wheel_angle_frame_odometer_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        track_byte(b);
        bytes_sent++;
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [7:0] sign, input logic [31:0] mag,
                              input logic [7:0] end_b);
        send_byte(addr);
        send_byte(cmd);
        send_byte(sign);
        send_byte(mag[31:24]);
        send_byte(mag[23:16]);
        send_byte(mag[15:8]);
        send_byte(mag[7:0]);
        send_byte(end_b);
    endtask

    function automatic logic [7:0] wheel_addr(input bit is_left);
        return is_left ? model_cfg.left_addr : model_cfg.right_addr;
    endfunction

    task automatic send_wheel(input bit is_left, input logic [7:0] sign, input logic [31:0] mag);
        send_frame(wheel_addr(is_left), model_cfg.cmd_byte, sign, mag, model_cfg.end_byte);
    endtask

    task automatic send_angle(input bit is_left, input longint a);
        logic [7:0] sign;
        longint     mag;
        if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
        if (a < 0 || (a == 0 && $urandom_range(0, 3) == 0)) begin
            sign = 8'($urandom_range(1, 255));
        end else begin
            sign = 8'd0;
        end
        mag = (a < 0) ? -a : a;
        send_wheel(is_left, sign, mag[31:0]);
    endtask

    function automatic longint pick_angle(input bit is_left);
        longint last;
        longint a;
        longint jump;
        last = is_left ? longint'(left_angle) : longint'(right_angle);
        case ($urandom_range(0, 3))
            0: begin
                a = longint'($urandom);
                if ($urandom_range(0, 1) == 1) a = -a;
            end
            1: a = last + longint'($urandom_range(0, 80000)) - 64'sd40000;
            2: begin
                // Right around half a turn, where the wrap correction starts.
                jump = longint'(32765 + $urandom_range(0, 6));
                a = ($urandom_range(0, 1) == 1) ? last + jump : last - jump;
            end
            default: a = last + longint'($urandom_range(0, 2097152)) - 64'sd1048576;
        endcase
        return a;
    endfunction

    function automatic int pick_gap_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic settle();
        push <= 1'b0;
        while (travel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Byte registers get random upper data bits, which must be ignored.
    task automatic write_config(input logic [7:0] left_a, input logic [7:0] right_a,
                                input logic [7:0] cmd, input logic [7:0] end_b,
                                input logic [23:0] scale);
        write_reg(CFG_LEFT_ADDR,  {16'($urandom), left_a});
        write_reg(CFG_RIGHT_ADDR, {16'($urandom), right_a});
        write_reg(CFG_CMD_BYTE,   {16'($urandom), cmd});
        write_reg(CFG_END_BYTE,   {16'($urandom), end_b});
        write_reg(CFG_MM_SCALE,   scale);
    endtask

    task automatic write_random_config();
        logic [7:0]  left_a;
        logic [7:0]  right_a;
        logic [23:0] scale;
        left_a = 8'($urandom);
        do right_a = 8'($urandom); while (right_a == left_a);
        case ($urandom_range(0, 3))
            0: scale = 24'd0;
            1: scale = 24'hFF_FFFF;
            2: scale = 24'($urandom);
            default: scale = 24'($urandom_range(0, 200000));
        endcase
        write_config(left_a, right_a, 8'($urandom), 8'($urandom), scale);
    endtask

    task automatic send_random_frame();
        int         kind;
        bit         is_left;
        logic [7:0] odd;
        kind = $urandom_range(0, 99);
        is_left = 1'($urandom_range(0, 1));
        if (kind < 70) begin
            send_angle(is_left, pick_angle(is_left));
        end else if (kind < 78) begin
            odd = 8'($urandom);
            if (odd == model_cfg.end_byte) odd = ~odd;
            send_frame(wheel_addr(is_left), model_cfg.cmd_byte, 8'($urandom), $urandom, odd);
        end else if (kind < 84) begin
            odd = ($urandom_range(0, 1) == 1) ? wheel_addr(!is_left) : 8'($urandom);
            if (odd == model_cfg.cmd_byte) odd = ~odd;
            send_byte(wheel_addr(is_left));
            send_byte(odd);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (kind < 95) begin
            // Truncated frame: the following bytes complete it.
            send_byte(wheel_addr(is_left));
            send_byte(model_cfg.cmd_byte);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
        end else begin
            odd = 8'($urandom);
            while (odd == model_cfg.left_addr || odd == model_cfg.right_addr) odd = odd + 8'd1;
            send_frame(odd, model_cfg.cmd_byte, 8'($urandom), $urandom, model_cfg.end_byte);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_first_frames();
        send_wheel(1'b1, 8'h00, 32'h0000_0000);
        send_wheel(1'b0, 8'h00, 32'hFFFF_FFFF);
        send_wheel(1'b1, 8'h00, 32'd1000);
        // Nonzero sign with a zero angle counts as zero.
        send_wheel(1'b0, 8'h80, 32'h0000_0000);
        send_wheel(1'b1, 8'hFF, 32'hFFFF_FFFF);
        send_wheel(1'b0, 8'h01, 32'd12345);
    endtask

    task automatic test_frame_hunting();
        // A wrong command byte equal to the right address must not start a frame.
        send_byte(model_cfg.left_addr);
        send_byte(model_cfg.right_addr);
        send_byte(model_cfg.cmd_byte);
        repeat (3) send_byte(8'h00);
        send_byte(8'h05);
        send_byte(model_cfg.end_byte);
        send_wheel(1'b0, 8'h00, 32'd100);
        send_frame(model_cfg.left_addr, model_cfg.cmd_byte, 8'h00, 32'd50,
                   model_cfg.end_byte ^ 8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_frame(8'h05, model_cfg.cmd_byte, 8'h00, 32'd7, model_cfg.end_byte);
        send_wheel(1'b1, 8'h00, 32'd200);
        // The newer left step replaces the older one before the right arrives.
        send_wheel(1'b1, 8'h00, 32'd260);
        send_wheel(1'b1, 8'h00, 32'd400);
        send_wheel(1'b0, 8'h00, 32'd90);
    endtask

    task automatic test_turn_wrap();
        send_angle(1'b1, longint'(left_angle) + 64'sd32768);
        send_angle(1'b0, longint'(right_angle) - 64'sd32768);
        send_angle(1'b1, longint'(left_angle) + 64'sd32769);
        send_angle(1'b0, longint'(right_angle) - 64'sd32769);
        send_angle(1'b1, longint'(left_angle) - 64'sd32768);
        send_angle(1'b0, longint'(right_angle) + 64'sd32769);
    endtask

    task automatic test_register_extremes();
        settle();
        write_config(8'd0, 8'd255, 8'h00, 8'hFF, 24'hFF_FFFF);
        send_angle(1'b1, -ANGLE_LIMIT);
        send_angle(1'b0, ANGLE_LIMIT);
        // Full-range steps in opposite directions saturate both ways.
        send_angle(1'b1, ANGLE_LIMIT);
        send_angle(1'b0, -ANGLE_LIMIT);
        send_angle(1'b1, -ANGLE_LIMIT);
        send_angle(1'b0, ANGLE_LIMIT);
        settle();
        write_reg(CFG_MM_SCALE, 24'd0);
        send_angle(1'b1, 64'sd5000);
        send_angle(1'b0, -64'sd5000);
        settle();
        // With one shared address every frame belongs to the left wheel.
        write_config(8'h80, 8'h80, 8'hFF, 8'h00, 24'd1);
        send_angle(1'b1, 64'sd10);
        send_angle(1'b0, 64'sd20);
        send_angle(1'b1, 64'sd30);
        settle();
        write_reg(CFG_UNUSED_IDX, 24'($urandom));
        write_config(RST_LEFT_ADDR, RST_RIGHT_ADDR, RST_CMD_BYTE, RST_END_BYTE, RST_MM_SCALE);
        send_angle(1'b0, 64'sd777);
        send_angle(1'b1, -64'sd777);
    endtask

    task automatic test_midframe_address();
        // Address registers change while a frame is half received; the stored
        // address is matched when the end byte arrives.
        send_frame(model_cfg.left_addr, model_cfg.cmd_byte, 8'h00, 32'd9000, 8'h00);
        send_byte(model_cfg.left_addr);
        send_byte(model_cfg.cmd_byte);
        repeat (5) send_byte(8'h01);
        settle();
        write_reg(CFG_LEFT_ADDR, 24'd9);
        write_reg(CFG_RIGHT_ADDR, {16'd0, RST_LEFT_ADDR});
        send_byte(model_cfg.end_byte);
        send_byte(8'd9);
        send_byte(model_cfg.cmd_byte);
        repeat (5) send_byte(8'h02);
        settle();
        write_reg(CFG_LEFT_ADDR, {16'd0, RST_LEFT_ADDR});
        write_reg(CFG_RIGHT_ADDR, {16'd0, RST_RIGHT_ADDR});
        send_byte(model_cfg.end_byte);
        send_angle(1'b1, pick_angle(1'b1));
        send_angle(1'b0, pick_angle(1'b0));
    endtask

    task automatic test_result_backpressure();
        settle();
        tx_gap_pct = 0;
        rx_hold_req = 500;
        repeat (12) begin
            send_angle(1'b1, pick_angle(1'b1));
            send_angle(1'b0, pick_angle(1'b0));
        end
        tx_gap_pct = 20;
    endtask

    task automatic test_random_traffic();
        int first_byte;
        int first_result;
        first_byte = bytes_sent;
        first_result = travel_made;
        while (bytes_sent - first_byte < RANDOM_BYTES ||
               travel_made - first_result < RANDOM_RESULTS) begin
            settle();
            write_random_config();
            tx_gap_pct = pick_gap_pct();
            rx_gap_pct = pick_gap_pct();
            repeat (16) send_random_frame();
        end
    endtask

    task automatic test_streaming();
        settle();
        write_random_config();
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        repeat (14) send_random_frame();
    endtask

    initial begin
        push <= 1'b0;
        i_rx_byte <= 8'd0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        errors = 0;
        stall_cycles = 0;
        travel_made = 0;
        bytes_sent = 0;
        rx_hold_req = 0;
        tx_gap_pct = 20;
        rx_gap_pct = 20;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_frames();
        test_frame_hunting();
        test_turn_wrap();
        test_register_extremes();
        test_midframe_address();
        test_result_backpressure();
        test_random_traffic();
        test_streaming();
        settle();

        if (errors == 0) begin
            $display("wheel_angle_frame_odometer_core_tb passed");
        end else begin
            $display("wheel_angle_frame_odometer_core_tb failed");
        end
        $finish;
    end

endmodule

@@ wheel_angle_frame_odometer_core.f @@
rtl/wafo_pkg.sv
rtl/wafo_front.sv
rtl/wafo_frame_q.sv
rtl/wafo_back.sv
rtl/wheel_angle_frame_odometer_core.sv
tb/sv/wheel_angle_frame_odometer_core_tb.sv
